// ===== rtl/transaction_status_table_macros.svh =====
// ----------------------------------------------------------------------------
// Transaction status table assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRANSACTION_STATUS_TABLE_MACROS_SVH
`define TRANSACTION_STATUS_TABLE_MACROS_SVH

// Same-cycle implication.
`define TST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// Transaction status table package
// Opcodes, status codes, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

    localparam int MAX_TXNS_DEF = 16;
    localparam int ID_BITS_DEF  = 32;
    localparam int OPCODE_W     = 3;
    localparam int TXN_ID_W     = 32;
    localparam int STEP_W       = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_NEW     = 3'd0,
        OP_COMMIT  = 3'd1,
        OP_ABORT   = 3'd2,
        OP_QUERY   = 3'd3,
        OP_RECOVER = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_COMMITTED = 2'd0,
        STAT_OPEN      = 2'd1,
        STAT_ABORTED   = 2'd2
    } txn_status_t;

    // Datapath action of one microcode step.
    typedef enum logic [2:0] {
        ACT_OUT,       // hand the result to the output register
        ACT_NEW,       // allocate an id and append it to the open list
        ACT_START,     // rewind the scan pointers
        ACT_REMOVE,    // compact the open list, dropping the first match
        ACT_APPEND,    // append the item's id to the aborted list
        ACT_HAS,       // look for the item's id in the selected list
        ACT_MOVE,      // copy every open id to the aborted list, flagging full when it has no room
        ACT_CLR_OPEN   // empty the open list
    } act_t;

    typedef enum logic [1:0] {
        J_GOTO,     // go to target
        J_LOOP,     // stay until the scan ends, then go to target
        J_LOOPHIT,  // stay until the scan ends, then target on a hit, else fall through
        J_OUT       // stay until the output register is free, then finish
    } jmp_t;

    typedef enum logic {
        SRC_OPEN,
        SRC_ABORT
    } src_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        act_t  act;
        src_t  src;
        jmp_t  jmp;
        step_t target;
    } tst_ctrl_t;

    // Conditions the datapath reports back to the sequencer.
    typedef struct packed {
        logic loop_done;
        logic hit;
        logic out_free;
    } tst_cond_t;

    localparam step_t STEP_DONE    = 4'd0;
    localparam step_t STEP_NEW     = 4'd1;
    localparam step_t STEP_COMMIT  = 4'd2;
    localparam step_t STEP_ABORT   = 4'd4;
    localparam step_t STEP_QUERY   = 4'd7;
    localparam step_t STEP_RECOVER = 4'd11;

    function automatic step_t entry_step(input logic [OPCODE_W-1:0] op);
        step_t s;
        case (op)
            OP_NEW:     s = STEP_NEW;
            OP_COMMIT:  s = STEP_COMMIT;
            OP_ABORT:   s = STEP_ABORT;
            OP_QUERY:   s = STEP_QUERY;
            OP_RECOVER: s = STEP_RECOVER;
            default:    s = STEP_DONE;
        endcase
        return s;
    endfunction

    // The microcode program, one control word per step.
    function automatic tst_ctrl_t ucode_rom(input step_t step);
        tst_ctrl_t w;
        case (step)
            4'd0:    w = '{ACT_OUT,      SRC_OPEN,  J_OUT,     STEP_DONE};
            4'd1:    w = '{ACT_NEW,      SRC_OPEN,  J_GOTO,    STEP_DONE};
            4'd2:    w = '{ACT_START,    SRC_OPEN,  J_GOTO,    4'd3};
            4'd3:    w = '{ACT_REMOVE,   SRC_OPEN,  J_LOOP,    STEP_DONE};
            4'd4:    w = '{ACT_START,    SRC_OPEN,  J_GOTO,    4'd5};
            4'd5:    w = '{ACT_REMOVE,   SRC_OPEN,  J_LOOP,    4'd6};
            4'd6:    w = '{ACT_APPEND,   SRC_ABORT, J_GOTO,    STEP_DONE};
            4'd7:    w = '{ACT_START,    SRC_ABORT, J_GOTO,    4'd8};
            4'd8:    w = '{ACT_HAS,      SRC_ABORT, J_LOOPHIT, STEP_DONE};
            4'd9:    w = '{ACT_START,    SRC_OPEN,  J_GOTO,    4'd10};
            4'd10:   w = '{ACT_HAS,      SRC_OPEN,  J_LOOP,    STEP_DONE};
            4'd11:   w = '{ACT_START,    SRC_OPEN,  J_GOTO,    4'd12};
            4'd12:   w = '{ACT_MOVE,     SRC_OPEN,  J_LOOP,    4'd13};
            4'd13:   w = '{ACT_CLR_OPEN, SRC_OPEN,  J_GOTO,    STEP_DONE};
            default: w = '{ACT_OUT,      SRC_OPEN,  J_OUT,     STEP_DONE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tst_list_mem.sv =====
// ----------------------------------------------------------------------------
// Transaction status table list memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_list_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tst_useq.sv =====
// ----------------------------------------------------------------------------
// Transaction status table microsequencer
// Step counter, microcode lookup and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_useq
    import tst_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire tst_cond_t           cond,
    output tst_ctrl_t                ctrl,
    output logic                     busy
);

    step_t step_reg, step_next;
    logic  busy_reg, busy_next;

    assign ctrl = ucode_rom(step_reg);
    assign busy = busy_reg;

    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            step_next = entry_step(opcode);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            case (ctrl.jmp)
                J_GOTO: begin
                    step_next = ctrl.target;
                end
                J_LOOP: begin
                    if (cond.loop_done) begin
                        step_next = ctrl.target;
                    end
                end
                J_LOOPHIT: begin
                    if (cond.loop_done) begin
                        step_next = cond.hit ? ctrl.target : step_t'(step_reg + 1'b1);
                    end
                end
                J_OUT: begin
                    if (cond.out_free) begin
                        busy_next = 1'b0;
                    end
                end
                default: begin
                    step_next = STEP_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_DONE;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/transaction_status_table.sv =====
// Throughput: one item at a time; s_tready rises at the edge that loads the result into
// the output register, so the next beat is taken in the following cycle at the earliest. Each
// list scan reads one entry per cycle from the single read port, which sets the loop length.
// Reset: aresetn clears both list counts, the id counter and all control state.
// ----------------------------------------------------------------------------
// Transaction status table
// Tracks open and aborted transaction ids in two bounded lists, driven by a
// small microcoded sequencer over a plain list datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "transaction_status_table_macros.svh"

module transaction_status_table
    import tst_pkg::*;
#(
    parameter int MAX_TXNS = MAX_TXNS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata, low bit up: opcode[2:0], txn_id[34:3], zero pad[39:35]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // m_tdata, low bit up: issued_id[31:0], txn_status[33:32], list_full[34],
    // zero pad[39:35]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata
);

    // Counts need to hold MAX_TXNS itself; addresses only reach MAX_TXNS - 1.
    localparam int CW = $clog2(MAX_TXNS + 1);
    localparam int AW = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TXNS);

    tst_ctrl_t ctrl;
    tst_cond_t cond;
    logic      busy;
    logic      accept;

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    // Item registers.
    logic [ID_BITS-1:0] id_reg, id_next;

    // Persistent state.
    logic [ID_BITS-1:0] last_issued_reg, last_issued_next;
    logic [CW-1:0]      open_count_reg, open_count_next;
    logic [CW-1:0]      ab_count_reg, ab_count_next;

    // Scan engine: read pointer, compaction write pointer, read-pending flag
    // and a hit flag that also marks the removed entry during compaction.
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;
    logic          pend_reg, pend_next;
    logic          hit_reg, hit_next;

    // Result under construction.
    logic [TXN_ID_W-1:0] issued_reg, issued_next;
    txn_status_t         status_reg, status_next;
    logic                full_reg, full_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [TXN_ID_W-1:0] m_issued_reg, m_issued_next;
    txn_status_t         m_status_reg, m_status_next;
    logic                m_full_reg, m_full_next;

    // Memory ports.
    logic               op_we, ab_we;
    logic [AW-1:0]      op_waddr, ab_waddr;
    logic [ID_BITS-1:0] op_wdata, ab_wdata;
    logic [ID_BITS-1:0] op_rdata, ab_rdata;

    logic               scan_act;
    logic [CW-1:0]      src_count;
    logic               rd_en;
    logic [ID_BITS-1:0] rd_data;
    logic               match;
    logic [ID_BITS-1:0] last_plus;

    tst_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .opcode  (s_tdata[2:0]),
        .cond    (cond),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    tst_list_mem #(
        .DEPTH (MAX_TXNS),
        .WIDTH (ID_BITS),
        .AW    (AW)
    ) u_open_mem (
        .aclk  (aclk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata (op_wdata),
        .re    (rd_en),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (op_rdata)
    );

    tst_list_mem #(
        .DEPTH (MAX_TXNS),
        .WIDTH (ID_BITS),
        .AW    (AW)
    ) u_abort_mem (
        .aclk  (aclk),
        .we    (ab_we),
        .waddr (ab_waddr),
        .wdata (ab_wdata),
        .re    (rd_en),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ab_rdata)
    );

    // A scan step reads one entry per cycle; the data comes back in the following cycle
    // and is handled while the next read is in flight.
    assign scan_act  = busy && (ctrl.act == ACT_REMOVE || ctrl.act == ACT_HAS ||
                                ctrl.act == ACT_MOVE);
    assign src_count = (ctrl.src == SRC_ABORT) ? ab_count_reg : open_count_reg;
    assign rd_en     = scan_act && (rd_idx_reg < src_count);
    assign rd_data   = (ctrl.src == SRC_ABORT) ? ab_rdata : op_rdata;
    assign match     = (rd_data == id_reg);
    assign last_plus = last_issued_reg + 1'b1;

    assign cond.loop_done = !rd_en && !pend_reg;
    assign cond.hit       = hit_reg;
    assign cond.out_free  = !m_valid_reg || m_tready;

    always_comb begin
        id_next          = id_reg;
        last_issued_next = last_issued_reg;
        open_count_next  = open_count_reg;
        ab_count_next    = ab_count_reg;
        rd_idx_next      = rd_en ? CW'(rd_idx_reg + 1'b1) : rd_idx_reg;
        wr_idx_next      = wr_idx_reg;
        pend_next        = rd_en;
        hit_next         = hit_reg;
        issued_next      = issued_reg;
        status_next      = status_reg;
        full_next        = full_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_issued_next    = m_issued_reg;
        m_status_next    = m_status_reg;
        m_full_next      = m_full_reg;
        op_we            = 1'b0;
        op_waddr         = open_count_reg[AW-1:0];
        op_wdata         = last_plus;
        ab_we            = 1'b0;
        ab_waddr         = ab_count_reg[AW-1:0];
        ab_wdata         = id_reg;

        if (accept) begin
            id_next     = ID_BITS'(s_tdata[34:3]);
            issued_next = '0;
            status_next = STAT_COMMITTED;
            full_next   = 1'b0;
        end else if (busy) begin
            case (ctrl.act)
                ACT_NEW: begin
                    if (open_count_reg >= MAX_CNT) begin
                        full_next = 1'b1;
                    end else begin
                        last_issued_next = last_plus;
                        op_we            = 1'b1;
                        open_count_next  = CW'(open_count_reg + 1'b1);
                        issued_next      = TXN_ID_W'(last_plus);
                    end
                end
                ACT_START: begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                end
                ACT_REMOVE: begin
                    // Every entry but the first match is written back at the write
                    // pointer, one place lower once past the match, so it trails the reads.
                    if (pend_reg) begin
                        if (!hit_reg && match) begin
                            hit_next = 1'b1;
                        end else begin
                            op_we       = 1'b1;
                            op_waddr    = wr_idx_reg[AW-1:0];
                            op_wdata    = rd_data;
                            wr_idx_next = CW'(wr_idx_reg + 1'b1);
                        end
                    end
                    if (cond.loop_done) begin
                        open_count_next = wr_idx_reg;
                    end
                end
                ACT_HAS: begin
                    if (pend_reg && match) begin
                        hit_next = 1'b1;
                    end
                    if (cond.loop_done && hit_reg) begin
                        status_next = (ctrl.src == SRC_ABORT) ? STAT_ABORTED : STAT_OPEN;
                    end
                end
                ACT_MOVE: begin
                    if (pend_reg) begin
                        if (ab_count_reg >= MAX_CNT) begin
                            full_next = 1'b1;
                        end else begin
                            ab_we         = 1'b1;
                            ab_wdata      = rd_data;
                            ab_count_next = CW'(ab_count_reg + 1'b1);
                        end
                    end
                end
                ACT_APPEND: begin
                    if (ab_count_reg >= MAX_CNT) begin
                        full_next = 1'b1;
                    end else begin
                        ab_we         = 1'b1;
                        ab_count_next = CW'(ab_count_reg + 1'b1);
                    end
                end
                ACT_CLR_OPEN: begin
                    open_count_next = '0;
                end
                ACT_OUT: begin
                    if (cond.out_free) begin
                        m_valid_next  = 1'b1;
                        m_issued_next = issued_reg;
                        m_status_next = status_reg;
                        m_full_next   = full_reg;
                    end
                end
                default: begin
                    full_next = full_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_issued_reg <= '0;
            open_count_reg  <= '0;
            ab_count_reg    <= '0;
            rd_idx_reg      <= '0;
            wr_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            last_issued_reg <= last_issued_next;
            open_count_reg  <= open_count_next;
            ab_count_reg    <= ab_count_next;
            rd_idx_reg      <= rd_idx_next;
            wr_idx_reg      <= wr_idx_next;
            pend_reg        <= pend_next;
            hit_reg         <= hit_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        issued_reg   <= issued_next;
        status_reg   <= status_next;
        full_reg     <= full_next;
        m_issued_reg <= m_issued_next;
        m_status_reg <= m_status_next;
        m_full_reg   <= m_full_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_full_reg, m_status_reg, m_issued_reg};

    // Neither list may grow past its capacity.
    `TST_ASSERT_IMP(a_counts_bounded, 1'b1,
        (open_count_reg <= MAX_CNT) && (ab_count_reg <= MAX_CNT),
        "list count exceeds capacity")

    // The aborted list only ever grows.
    `TST_ASSERT_IMP(a_abort_monotonic, $past(aresetn),
        ab_count_reg >= $past(ab_count_reg), "aborted count decreased")

    // Compaction must never overwrite an entry that has not been read yet.
    `TST_ASSERT_IMP(a_compact_order, busy && ctrl.act == ACT_REMOVE,
        wr_idx_reg <= rd_idx_reg, "compaction write pointer passed read pointer")

    // A failed append never hands out an id.
    `TST_ASSERT_IMP(a_full_no_id, m_valid_reg && m_full_reg,
        m_issued_reg == '0, "list_full result carries an issued id")

    // A new result is only loaded by a busy sequencer.
    `TST_ASSERT_NXT(a_load_when_busy, !busy && !m_valid_reg, !m_valid_reg,
        "result appeared without an item in work")

endmodule

`default_nettype wire
